@@ sv/spa_pkg.sv @@
// shared types and constants of the sparse polynomial adder
package spa_pkg;

    // field widths
    localparam int COEFF_W = 16;
    localparam int EXP_W   = 16;
    localparam int SUM_W   = 17;
    localparam int OP_W    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_MERGE       = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic step_last;
    } t_status;

endpackage

@@ sv/spa_datapath.sv @@
// term stores, merge heads and result payload register
module spa_datapath
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic signed [COEFF_W-1:0] i_coeff,
    input  logic [EXP_W-1:0]          i_exponent,
    output t_status                   o_status,
    output logic signed [SUM_W-1:0]   o_sum_coeff,
    output logic [EXP_W-1:0]          o_result_exponent,
    output logic                      o_last_term,
    output logic                      o_no_terms
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // term stores
    logic signed [COEFF_W-1:0] r_first_c  [MAX_TERMS];
    logic [EXP_W-1:0]          r_first_e  [MAX_TERMS];
    logic signed [COEFF_W-1:0] r_second_c [MAX_TERMS];
    logic [EXP_W-1:0]          r_second_e [MAX_TERMS];

    logic [CW-1:0] r_cnt1, n_cnt1, r_cnt2, n_cnt2;
    logic [CW-1:0] r_i, n_i, r_j, n_j;

    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [EXP_W-1:0]        r_exp, n_exp;
    logic                    r_last, n_last;
    logic                    r_none, n_none;

    logic                      has_i, has_j, take_i, take_j;
    logic signed [COEFF_W-1:0] c1, c2;
    logic [EXP_W-1:0]          e1, e2;
    logic [CW-1:0]             adv_i, adv_j;
    logic                      room1, room2;

    // heads of both stores
    assign c1 = r_first_c[r_i[IW-1:0]];
    assign e1 = r_first_e[r_i[IW-1:0]];
    assign c2 = r_second_c[r_j[IW-1:0]];
    assign e2 = r_second_e[r_j[IW-1:0]];

    assign has_i = (r_i < r_cnt1);
    assign has_j = (r_j < r_cnt2);
    assign room1 = (r_cnt1 < CW'(MAX_TERMS));
    assign room2 = (r_cnt2 < CW'(MAX_TERMS));

    // merge decision
    always_comb begin
        take_i = 1'b0;
        take_j = 1'b0;
        priority if (has_i && has_j) begin
            priority if (e1 == e2) begin
                take_i = 1'b1;
                take_j = 1'b1;
            end else if (e1 > e2) begin
                take_i = 1'b1;
            end else begin
                take_j = 1'b1;
            end
        end else if (has_i) begin
            take_i = 1'b1;
        end else if (has_j) begin
            take_j = 1'b1;
        end else begin
            // both stores exhausted
            take_i = 1'b0;
            take_j = 1'b0;
        end
    end

    assign adv_i = r_i + CW'(take_i);
    assign adv_j = r_j + CW'(take_j);

    // result term of this step
    always_comb begin
        n_sum  = r_sum;
        n_exp  = r_exp;
        n_last = r_last;
        n_none = r_none;
        if (i_cmd.step) begin
            n_last = (adv_i >= r_cnt1) && (adv_j >= r_cnt2);
            n_none = !take_i && !take_j;
            priority if (take_i && take_j) begin
                n_sum = SUM_W'(c1) + SUM_W'(c2);
                n_exp = e1;
            end else if (take_i) begin
                n_sum = SUM_W'(c1);
                n_exp = e1;
            end else if (take_j) begin
                n_sum = SUM_W'(c2);
                n_exp = e2;
            end else begin
                n_sum = '0;
                n_exp = '0;
            end
        end
    end

    // counts and heads
    always_comb begin
        n_cnt1 = r_cnt1;
        n_cnt2 = r_cnt2;
        n_i    = r_i;
        n_j    = r_j;
        if (i_cmd.load_first && room1) begin
            n_cnt1 = r_cnt1 + CW'(1);
        end
        if (i_cmd.load_second && room2) begin
            n_cnt2 = r_cnt2 + CW'(1);
        end
        if (i_cmd.step) begin
            if (o_status.step_last) begin
                n_i    = '0;
                n_j    = '0;
                n_cnt1 = '0;
                n_cnt2 = '0;
            end else begin
                n_i = adv_i;
                n_j = adv_j;
            end
        end
    end

    assign o_status.step_last = (adv_i >= r_cnt1) && (adv_j >= r_cnt2);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1 <= '0;
            r_cnt2 <= '0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            r_cnt1 <= n_cnt1;
            r_cnt2 <= n_cnt2;
            r_i    <= n_i;
            r_j    <= n_j;
        end
    end

    // store writes and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && room1) begin
            r_first_c[r_cnt1[IW-1:0]] <= i_coeff;
            r_first_e[r_cnt1[IW-1:0]] <= i_exponent;
        end
        if (i_cmd.load_second && room2) begin
            r_second_c[r_cnt2[IW-1:0]] <= i_coeff;
            r_second_e[r_cnt2[IW-1:0]] <= i_exponent;
        end
        r_sum  <= n_sum;
        r_exp  <= n_exp;
        r_last <= n_last;
        r_none <= n_none;
    end

    assign o_sum_coeff       = r_sum;
    assign o_result_exponent = r_exp;
    assign o_last_term       = r_last;
    assign o_no_terms        = r_none;

    // heads never pass the fill counts
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt1) && (r_j <= r_cnt2))
        else $error("merge head beyond fill count");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt1 <= CW'(MAX_TERMS)) && (r_cnt2 <= CW'(MAX_TERMS)))
        else $error("store count above capacity");

    // an empty step is only the lone no-terms result
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !take_i && !take_j) |-> o_status.step_last)
        else $error("empty merge step not final");

endmodule

@@ sv/spa_ctrl.sv @@
// handshake control and merge sequencing
module spa_ctrl
    import spa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_operation,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  t_status         i_status,
    output t_cmd            o_cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic in_xfer, out_free, step;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = (r_state == ST_MERGE) && out_free;

    // commands
    assign o_cmd.load_first  = in_xfer && (i_operation == OP_LOAD_FIRST);
    assign o_cmd.load_second = in_xfer && (i_operation == OP_LOAD_SECOND);
    assign o_cmd.step        = step;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_operation == OP_MERGE)) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (step && i_status.step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // final step ends the merge
    a_last_ends_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_status.step_last) |=> (r_state == ST_IDLE))
        else $error("merge did not end after final term");

    // a result appears only from a merge step
    a_valid_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step))
        else $error("result valid without merge step");

    // a waiting result stays offered
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped before transfer");

endmodule

@@ sv/sparse_polynomial_adder.sv @@
// top level of the sparse polynomial adder
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_operation, i_coeff, i_exponent
//  output  | o_out_valid | i_out_ready | o_sum_coeff, o_result_exponent,
//          |             |             | o_last_term, o_no_terms
//
// a load writes a term while its store has room; a merge opcode enters the merge
// state, which emits one term per cycle, n1 + n2 terms at most and one when both
// stores are empty; the single-term merge step over both store heads sets the rate.
// a stalled output holds the merge; loads are taken while the last term waits.
// synchronous active-low reset empties both stores; store contents are not cleared.
module sparse_polynomial_adder
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_operation,
    input  logic signed [COEFF_W-1:0] i_coeff,
    input  logic [EXP_W-1:0]          i_exponent,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SUM_W-1:0]   o_sum_coeff,
    output logic [EXP_W-1:0]          o_result_exponent,
    output logic                      o_last_term,
    output logic                      o_no_terms
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    spa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // stores and merge
    spa_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_coeff           (i_coeff),
        .i_exponent        (i_exponent),
        .o_status          (status),
        .o_sum_coeff       (o_sum_coeff),
        .o_result_exponent (o_result_exponent),
        .o_last_term       (o_last_term),
        .o_no_terms        (o_no_terms)
    );

endmodule
